>>> rtl/msts_pkg.sv
// Package for the multi-stream timestamp synchronizer.
// Verdict codes, register indexes, pivot modes and default sizes; no dependencies.
package msts_pkg;

  localparam int unsigned DefStreams     = 8;
  localparam int unsigned DefPayloadBits = 64;

  localparam logic [1:0] CfgStreamCount = 2'd0;
  localparam logic [1:0] CfgTolerance   = 2'd1;
  localparam logic [1:0] CfgPivotMode   = 2'd2;
  localparam logic [1:0] CfgAnchorIndex = 2'd3;

  localparam logic [1:0] PivotMax    = 2'd0;
  localparam logic [1:0] PivotMin    = 2'd1;
  localparam logic [1:0] PivotAnchor = 2'd2;

  typedef enum logic [2:0] {
    VerdictInvalid   = 3'd0,
    VerdictStale     = 3'd1,
    VerdictHeld      = 3'd2,
    VerdictCoalesced = 3'd3,
    VerdictGap       = 3'd4,
    VerdictTuple     = 3'd5
  } verdict_t;

  // Token passed from cell to cell along the scan.
  typedef struct packed {
    logic        all_armed;
    logic        have;      // pivot/laggard seen
    logic signed [63:0] pivot;
    logic signed [63:0] lag_time;
    logic [4:0]  lag_idx;
    logic        any_out;
  } scan_t;

  // Control broadcast to every cell for the current pass.
  typedef struct packed {
    logic [1:0] pass;       // 0 armed+pivot, 1 tolerance check
    logic [1:0] mode;
    logic [4:0] anchor;
    logic [4:0] n;
    logic signed [63:0] pivot;
  } scan_ctl_t;

  localparam logic [1:0] PassPivot = 2'd0;
  localparam logic [1:0] PassCheck = 2'd1;

  function automatic logic signed [63:0] sat_add(input logic [62:0] t,
                                                 input logic signed [63:0] off);
    logic signed [64:0] s;
    s = $signed({2'b00, t}) + $signed({off[63], off});
    // 64-bit overflow shows as bit 64 differing from bit 63
    if (s[64] != s[63]) sat_add = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    else sat_add = s[63:0];
  endfunction

  function automatic logic [64:0] abs_diff(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    abs_diff = d[64] ? 65'(-d) : 65'(d);
  endfunction

endpackage

>>> rtl/msts_cell.sv
// One scan cell: folds one lane into the token handed to the next cell.
// Depends on msts_pkg.
module msts_cell import msts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [4:0]        idx,
  input  logic              armed,
  input  logic signed [63:0] eff,
  input  logic [63:0]       tolerance,
  input  scan_ctl_t         ctl,
  input  scan_t             tok_in,
  output scan_t             tok_r,
  output logic              rel_r
);
  scan_t tok_nxt;
  logic  in_use;
  logic  beyond;
  logic  rel_nxt;

  always_comb begin
    in_use  = idx < ctl.n;
    beyond  = abs_diff(eff, ctl.pivot) > {1'b0, tolerance};
    rel_nxt = in_use && beyond && !(ctl.mode == PivotAnchor && idx == ctl.anchor);
    tok_nxt = tok_in;
    if (in_use) begin
      if (ctl.pass == PassPivot) begin
        if (!armed) tok_nxt.all_armed = 1'b0;
        if (!tok_in.have ||
            (ctl.mode == PivotMin ? eff < tok_in.pivot : eff > tok_in.pivot))
          tok_nxt.pivot = eff;
        if (!tok_in.have || eff < tok_in.lag_time) begin
          tok_nxt.lag_time = eff;
          tok_nxt.lag_idx  = idx;
        end
        tok_nxt.have = 1'b1;
      end else if (rel_nxt) begin
        tok_nxt.any_out = 1'b1;
      end
    end
  end

  // rel_r marks this lane for release in anchor mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      rel_r <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
      if (ctl.pass == PassCheck) rel_r <= rel_nxt;
    end
  end
endmodule

>>> rtl/multi_stream_timestamp_synchronizer.sv
// Top level of the multi-stream timestamp synchronizer.
// Depends on msts_pkg and msts_cell.
//
// Usage: raise start with the in_* fields; the item is taken at a rising edge
// with busy low. Kind 1 writes a stream offset at that edge, gives no result
// and leaves busy low. Kind 0 offers a sample. Invalid, stale and non-anchor
// arrivals answer with one result from StReply after StOffer. Otherwise a
// token walks the row of STREAMS cells, one lane per cycle, for the armed
// check, pivot and laggard; if a lane is still empty the held/coalesced
// result follows from StPick via StReply. Else a second walk checks the
// tolerance: a gap answers from StJudge via StReply, and a tuple streams its
// n members from StEmit, one per cycle, last flagged. The block takes no new
// item until the current one is done. Each result shows for one cycle with
// out_valid high; the receiver cannot stall. Counter ports always show the
// values after the latest item. Reset clears arming, offsets, counters and
// configuration (stream_count 1, the rest 0). Write cfg_we/cfg_index/cfg_data
// only while idle.
module multi_stream_timestamp_synchronizer import msts_pkg::*; #(
  parameter int unsigned STREAMS      = DefStreams,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [2:0]  in_stream,
  input  logic [62:0] in_sample_time,
  input  logic [63:0] in_sample_payload,
  input  logic signed [63:0] in_offset,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_verdict,
  output logic [2:0]  out_stream,
  output logic [62:0] out_time,
  output logic [63:0] out_payload,
  output logic        out_last,
  output logic [31:0] out_stale_count,
  output logic [31:0] out_coalesced_count,
  output logic [31:0] out_gap_count,
  output logic [31:0] out_tuple_count
);
  localparam int unsigned LW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int unsigned CW = $clog2(STREAMS + 1);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StOffer = 8'b0000_0010,
    StScan0 = 8'b0000_0100,
    StPick  = 8'b0000_1000,
    StScan1 = 8'b0001_0000,
    StJudge = 8'b0010_0000,
    StEmit  = 8'b0100_0000,
    StReply = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]  cnt_cfg_r;
  logic [63:0] tol_r;
  logic [1:0]  mode_cfg_r;
  logic [2:0]  anchor_r;

  logic signed [63:0] off_r  [STREAMS];
  logic signed [63:0] eff_r  [STREAMS];
  logic [62:0]        orig_r [STREAMS];
  logic [PAYLOAD_BITS-1:0] pay_r [STREAMS];
  logic [STREAMS-1:0] armed_r;

  logic [31:0] stale_r, coal_r, gap_r, tup_r;

  logic [2:0]  s_r;
  logic [62:0] t_r;
  logic [63:0] p_r;
  logic [2:0]  verdict_r;
  logic [CW-1:0] step_r;
  logic [LW-1:0] emit_r;
  logic signed [63:0] pivot_r;
  logic [4:0]  lag_r;

  logic [4:0]  n;
  logic [1:0]  mode;
  logic [LW-1:0] s_idx;
  logic [LW-1:0] anc_idx;
  logic signed [63:0] tau;
  logic        s_in_use;
  logic        stale;
  logic        go_scan;
  logic        step_last;
  logic        emit_last;

  scan_t     tok [STREAMS+1];
  scan_t     tok_head;
  scan_t     fin;
  scan_ctl_t ctl;
  logic      scan_en;
  logic [STREAMS-1:0] rel;
  logic [STREAMS-1:0] use_mask;
  logic [CW-1:0]      rel_cnt;

  assign n        = ({2'b00, cnt_cfg_r} < 6'(STREAMS)) ? {1'b0, cnt_cfg_r} : 5'(STREAMS);
  assign mode     = (mode_cfg_r == 2'd3) ? PivotMax : mode_cfg_r;
  assign s_idx    = LW'(s_r);
  assign anc_idx  = LW'(anchor_r);
  assign tau      = sat_add(t_r, off_r[s_idx]);
  assign s_in_use = {2'b00, s_r} < n;
  assign stale    = armed_r[s_idx] && (tau < eff_r[s_idx]);
  // non-anchor arrivals in anchor mode never attempt a tuple
  assign go_scan  = s_in_use && !stale && !(mode == PivotAnchor && s_r != anchor_r);
  assign step_last = step_r == CW'(STREAMS - 1);
  assign emit_last = 32'(emit_r) + 32'd1 == 32'(n);

  // chain of cells
  always_comb begin
    tok_head           = '0;
    tok_head.all_armed = 1'b1;
    ctl.pass    = (state_r == StScan1) ? PassCheck : PassPivot;
    ctl.mode    = mode;
    ctl.anchor  = {2'b00, anchor_r};
    ctl.n       = n;
    ctl.pivot   = pivot_r;
  end

  assign scan_en = (state_r == StScan0) || (state_r == StScan1);
  assign tok[0]  = tok_head;

  genvar g;
  generate
    for (g = 0; g < STREAMS; g++) begin : g_cell
      msts_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (scan_en && step_r == CW'(g)),
        .idx       (5'(g)),
        .armed     (armed_r[g]),
        .eff       (eff_r[g]),
        .tolerance (tol_r),
        .ctl       (ctl),
        .tok_in    (tok[g]),
        .tok_r     (tok[g+1]),
        .rel_r     (rel[g])
      );
    end
  endgenerate

  assign fin = tok[STREAMS];

  always_comb begin
    rel_cnt = CW'($countones(rel));
    for (int i = 0; i < STREAMS; i++) use_mask[i] = 32'(i) < 32'(n);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      StIdle:  if (start && !in_kind) state_nxt = StOffer;
      StOffer: state_nxt = go_scan ? StScan0 : StReply;
      StScan0: if (step_last) state_nxt = StPick;
      StPick:  state_nxt = fin.all_armed ? StScan1 : StReply;
      StScan1: if (step_last) state_nxt = StJudge;
      StJudge: state_nxt = fin.any_out ? StReply : StEmit;
      StEmit:  if (emit_last) state_nxt = StIdle;
      StReply: state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  assign busy = state_r != StIdle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= StIdle;
      cnt_cfg_r  <= 4'd1;
      tol_r      <= '0;
      mode_cfg_r <= PivotMax;
      anchor_r   <= '0;
      armed_r    <= '0;
      stale_r    <= '0;
      coal_r     <= '0;
      gap_r      <= '0;
      tup_r      <= '0;
      step_r     <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < STREAMS; i++) off_r[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgStreamCount: cnt_cfg_r  <= cfg_data[3:0];
          CfgTolerance:   tol_r      <= cfg_data;
          CfgPivotMode:   mode_cfg_r <= cfg_data[1:0];
          CfgAnchorIndex: anchor_r   <= cfg_data[2:0];
          default: ;
        endcase
      end
      unique case (state_r)
        StIdle: begin
          s_r <= in_stream;
          t_r <= in_sample_time;
          p_r <= in_sample_payload;
          if (start && in_kind && {2'b00, in_stream} < n) begin
            off_r[LW'(in_stream)] <= in_offset;
            if (armed_r[LW'(in_stream)])
              eff_r[LW'(in_stream)] <= sat_add(orig_r[LW'(in_stream)], in_offset);
          end
        end
        StOffer: begin
          step_r <= '0;
          if (!s_in_use) begin
            verdict_r <= VerdictInvalid;
          end else if (stale) begin
            verdict_r <= VerdictStale;
            stale_r   <= stale_r + 32'd1;
          end else begin
            if (armed_r[s_idx]) coal_r <= coal_r + 32'd1;
            orig_r[s_idx]   <= t_r;
            pay_r[s_idx]    <= p_r[PAYLOAD_BITS-1:0];
            eff_r[s_idx]    <= tau;
            armed_r[s_idx]  <= 1'b1;
            verdict_r <= armed_r[s_idx] ? VerdictCoalesced : VerdictHeld;
          end
        end
        StScan0, StScan1: begin
          step_r <= step_r + CW'(1);
        end
        StPick: begin
          step_r  <= '0;
          pivot_r <= (mode == PivotAnchor) ? eff_r[anc_idx] : fin.pivot;
          lag_r   <= fin.lag_idx;
        end
        StJudge: begin
          if (fin.any_out) begin
            verdict_r <= VerdictGap;
            if (mode == PivotAnchor) begin
              gap_r   <= gap_r + 32'(rel_cnt);
              armed_r <= armed_r & ~rel;
            end else begin
              gap_r <= gap_r + 32'd1;
              armed_r[LW'(lag_r)] <= 1'b0;
            end
          end else begin
            tup_r   <= tup_r + 32'd1;
            armed_r <= armed_r & ~use_mask;
            emit_r  <= '0;
          end
        end
        StEmit: begin
          out_valid   <= 1'b1;
          out_verdict <= VerdictTuple;
          out_stream  <= 3'(emit_r);
          out_time    <= orig_r[emit_r];
          out_payload <= 64'(pay_r[emit_r]);
          out_last    <= emit_last;
          emit_r      <= emit_r + LW'(1);
        end
        StReply: begin
          out_valid   <= 1'b1;
          out_verdict <= verdict_r;
          out_stream  <= '0;
          out_time    <= '0;
          out_payload <= '0;
          out_last    <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_stale_count     = stale_r;
  assign out_coalesced_count = coal_r;
  assign out_gap_count       = gap_r;
  assign out_tuple_count     = tup_r;
endmodule

>>> dv/multi_stream_timestamp_synchronizer_tb.sv
// Testbench for the multi-stream timestamp synchronizer: random and directed items
// checked field by field against a behavioral predictor. Depends on msts_pkg and the RTL.
module multi_stream_timestamp_synchronizer_tb;
  import msts_pkg::*;

  typedef struct {
    logic        kind;
    logic [2:0]  stream;
    logic [62:0] stime;
    logic [63:0] payload;
    logic [63:0] offset;
  } offer_t;

  typedef struct {
    logic [2:0]  verdict;
    logic [2:0]  strm;
    logic [62:0] otime;
    logic [63:0] payload;
    logic        last;
    logic [31:0] stale_c, coal_c, gap_c, tup_c;
  } sync_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_kind = 0;
  logic [2:0] in_stream = 0;
  logic [62:0] in_sample_time = 0;
  logic [63:0] in_sample_payload = 0;
  logic signed [63:0] in_offset = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;
  logic out_valid, out_last;
  logic [2:0] out_verdict, out_stream;
  logic [62:0] out_time;
  logic [63:0] out_payload;
  logic [31:0] out_stale_count, out_coalesced_count, out_gap_count, out_tuple_count;

  multi_stream_timestamp_synchronizer u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [3:0]  p_count;
  logic [63:0] p_tol;
  logic [1:0]  p_mode;
  logic [2:0]  p_anchor;
  logic signed [63:0] lane_off [8];
  logic        lane_arm [8];
  logic signed [63:0] lane_eff [8];
  logic [62:0] lane_orig [8];
  logic [63:0] lane_pay [8];
  logic [31:0] n_stale, n_coal, n_gap, n_tuple;

  offer_t    pending_items [$];
  sync_res_t expected_results [$];
  int errors = 0;
  bit feeding = 0;
  int n_taken = 0;
  int n_issued = 0;

  function automatic logic signed [63:0] shift_time(logic [62:0] t, logic signed [63:0] off);
    logic signed [64:0] s;
    s = $signed({2'b00, t}) + $signed({off[63], off});
    if (s > $signed(65'h0_7FFF_FFFF_FFFF_FFFF)) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (s < -$signed(65'h0_8000_0000_0000_0000)) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic [64:0] lane_gap(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] d;
    d = $signed({a[63], a}) - $signed({b[63], b});
    return d < 0 ? -d : d;
  endfunction

  task automatic push_fixed(logic [2:0] v);
    sync_res_t r;
    r = '{v, 0, 0, 0, 1, n_stale, n_coal, n_gap, n_tuple};
    expected_results.push_back(r);
  endtask

  task automatic predict_sync(offer_t it);
    int n, s, lag;
    logic [1:0] m;
    logic signed [63:0] tau, pv;
    logic replaced, any_out;
    sync_res_t r;
    n = p_count > 8 ? 8 : p_count;
    s = it.stream;
    m = (p_mode == 2'd3) ? PivotMax : p_mode;
    if (it.kind) begin
      if (s < n) begin
        lane_off[s] = it.offset;
        if (lane_arm[s]) lane_eff[s] = shift_time(lane_orig[s], it.offset);
      end
      return;
    end
    if (s >= n) begin
      push_fixed(VerdictInvalid);
      return;
    end
    tau = shift_time(it.stime, lane_off[s]);
    if (lane_arm[s] && tau < lane_eff[s]) begin
      n_stale++;
      push_fixed(VerdictStale);
      return;
    end
    replaced = lane_arm[s];
    if (replaced) n_coal++;
    lane_orig[s] = it.stime;
    lane_pay[s] = it.payload;
    lane_arm[s] = 1;
    lane_eff[s] = tau;
    if (m == PivotAnchor && s != p_anchor) begin
      push_fixed(replaced ? VerdictCoalesced : VerdictHeld);
      return;
    end
    for (int i = 0; i < n; i++)
      if (!lane_arm[i]) begin
        push_fixed(replaced ? VerdictCoalesced : VerdictHeld);
        return;
      end
    if (m == PivotAnchor) begin
      any_out = 0;
      pv = lane_eff[p_anchor];
      for (int i = 0; i < n; i++)
        if (i != p_anchor && lane_gap(lane_eff[i], pv) > {1'b0, p_tol}) begin
          lane_arm[i] = 0;
          n_gap++;
          any_out = 1;
        end
      if (any_out) begin
        push_fixed(VerdictGap);
        return;
      end
    end else begin
      pv = lane_eff[0];
      for (int i = 1; i < n; i++)
        if (m == PivotMax ? lane_eff[i] > pv : lane_eff[i] < pv) pv = lane_eff[i];
      for (int i = 0; i < n; i++)
        if (lane_gap(lane_eff[i], pv) > {1'b0, p_tol}) begin
          lag = 0;
          for (int j = 1; j < n; j++) if (lane_eff[j] < lane_eff[lag]) lag = j;
          lane_arm[lag] = 0;
          n_gap++;
          push_fixed(VerdictGap);
          return;
        end
    end
    n_tuple++;
    for (int i = 0; i < n; i++) begin
      lane_arm[i] = 0;
      r = '{VerdictTuple, i[2:0], lane_orig[i], lane_pay[i], (i + 1 == n),
            n_stale, n_coal, n_gap, n_tuple};
      expected_results.push_back(r);
    end
  endtask

  // driver: bursts with random gaps; start held until the item is taken
  int gap_left = 0;
  always @(negedge clk) begin
    offer_t it;
    logic nxt_start;
    nxt_start = start;
    if (start && n_taken == n_issued) nxt_start = 0;
    if (!rst_n) begin
      nxt_start = 0;
    end else if (!nxt_start && feeding && pending_items.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        it = pending_items[0];
        in_kind <= it.kind;
        in_stream <= it.stream;
        in_sample_time <= it.stime;
        in_sample_payload <= it.payload;
        in_offset <= it.offset;
        nxt_start = 1;
        n_issued++;
        if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 30);
      end
    end
    start <= nxt_start;
  end

  // acceptance and result checking at the rising edge
  always @(posedge clk) begin
    sync_res_t e;
    if (rst_n && start && !busy) begin
      predict_sync(pending_items.pop_front());
      n_taken++;
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: verdict %0d", out_verdict);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_verdict !== e.verdict) begin
          $error("verdict exp %0d got %0d", e.verdict, out_verdict); errors++; end
        if (out_stream !== e.strm) begin
          $error("out_stream exp %0d got %0d", e.strm, out_stream); errors++; end
        if (out_time !== e.otime) begin
          $error("out_time exp %h got %h", e.otime, out_time); errors++; end
        if (out_payload !== e.payload) begin
          $error("out_payload exp %h got %h", e.payload, out_payload); errors++; end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++; end
        if (out_stale_count !== e.stale_c) begin
          $error("stale_count exp %0d got %0d", e.stale_c, out_stale_count); errors++; end
        if (out_coalesced_count !== e.coal_c) begin
          $error("coalesced_count exp %0d got %0d", e.coal_c, out_coalesced_count);
          errors++;
        end
        if (out_gap_count !== e.gap_c) begin
          $error("gap_count exp %0d got %0d", e.gap_c, out_gap_count); errors++; end
        if (out_tuple_count !== e.tup_c) begin
          $error("tuple_count exp %0d got %0d", e.tup_c, out_tuple_count); errors++; end
      end
    end
  end

  task automatic add_item(logic k, logic [2:0] s, logic [62:0] t, logic [63:0] p,
                          logic [63:0] o);
    offer_t it;
    it = '{k, s, t, p, o};
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CfgStreamCount: p_count = val[3:0];
      CfgTolerance:   p_tol = val;
      CfgPivotMode:   p_mode = val[1:0];
      default:        p_anchor = val[2:0];
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // run queued items, then wait until idle
  task automatic drain();
    feeding = 1;
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    feeding = 0;
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [62:0] rnd63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed rounds: nearby times on random lanes below nlanes, random order
  task automatic random_round(int nlanes, logic [62:0] base, int spread);
    for (int i = 0; i < nlanes + 2; i++) begin
      case ($urandom_range(0, 19))
        0: add_item(1, 3'($urandom_range(0, 7)), rnd63(), rnd64(),
                    $signed(64'($urandom_range(0, 40))) - 20);
        1: add_item(0, 3'($urandom_range(0, 7)), rnd63(), rnd64(), rnd64());
        2: add_item(1, 3'($urandom_range(0, 7)), 0, 0, rnd64());
        default: add_item(0, 3'($urandom_range(0, nlanes - 1)),
                          base + 63'($urandom_range(0, spread)), rnd64(), rnd64());
      endcase
    end
  endtask

  initial begin
    int cfg_pick;
    p_count = 1; p_tol = 0; p_mode = 0; p_anchor = 0;
    n_stale = 0; n_coal = 0; n_gap = 0; n_tuple = 0;
    for (int i = 0; i < 8; i++) begin
      lane_off[i] = 0; lane_arm[i] = 0; lane_eff[i] = 0; lane_orig[i] = 0; lane_pay[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single lane extremes, stale, invalid stream
    add_item(0, 0, '1, '1, 0);
    add_item(0, 1, 0, 0, 0);
    add_item(0, 0, 0, 64'h1, 0);
    write_reg(CfgStreamCount, 4);
    write_reg(CfgTolerance, 10);
    drain();
    add_item(0, 0, 100, 1, 0);
    add_item(0, 0, 50, 2, 0);            // stale
    add_item(0, 0, 120, 3, 0);           // coalesced
    add_item(0, 1, 115, 4, 0);
    add_item(0, 2, 200, 5, 0);
    add_item(0, 3, 118, 6, 0);           // laggard released
    add_item(0, 0, 195, 7, 0);
    add_item(0, 1, 198, 8, 0);
    add_item(0, 3, 199, 9, 0);           // tuple
    add_item(1, 5, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF); // ignored, out of range
    add_item(1, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    add_item(0, 0, '1, 0, 0);            // saturates high
    add_item(1, 0, 0, 0, 64'h8000_0000_0000_0000); // re-time armed lane low
    add_item(1, 0, 0, 0, 0);
    drain();
    write_reg(CfgPivotMode, PivotAnchor);
    write_reg(CfgAnchorIndex, 2);
    write_reg(CfgTolerance, 0);
    add_item(0, 1, 500, 1, 0);
    add_item(0, 3, 900, 2, 0);
    add_item(0, 2, 500, 3, 0);           // gap releases outlier lanes
    drain();
    write_reg(CfgAnchorIndex, 7);        // anchor beyond count
    add_item(0, 2, 600, 4, 0);
    drain();
    write_reg(CfgStreamCount, 0);
    add_item(0, 0, 1, 1, 0);             // no stream in use
    drain();
    write_reg(CfgPivotMode, 3);
    write_reg(CfgStreamCount, 15);
    write_reg(CfgTolerance, '1);
    for (int i = 0; i < 8; i++) add_item(0, 3'(i), rnd63(), rnd64(), 0);
    drain();

    // random phases over many settings
    for (int ph = 0; ph < 14; ph++) begin
      cfg_pick = $urandom_range(1, 8);
      write_reg(CfgStreamCount, ph == 0 ? 8 : (ph == 1 ? 1 : cfg_pick));
      write_reg(CfgPivotMode, $urandom_range(0, 3));
      write_reg(CfgAnchorIndex, $urandom_range(0, 9) == 0 ? 7 : $urandom_range(0, cfg_pick - 1));
      write_reg(CfgTolerance, ph == 2 ? '1 : (ph == 3 ? 0 : $urandom_range(0, 60)));
      for (int r = 0; r < 5; r++)
        random_round(cfg_pick, $urandom_range(0, 3) == 0 ? '1 - 100 : rnd63() >> $urandom_range(0, 62),
                     $urandom_range(0, 80));
      if (ph == 7) begin
        drain();                       // sender pause until all results are in
      end
      drain();
    end

    if (errors == 0) $display("multi_stream_timestamp_synchronizer_tb: clean");
    else $display("multi_stream_timestamp_synchronizer_tb: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("multi_stream_timestamp_synchronizer_tb: errors");
    $finish;
  end
endmodule

>>> multi_stream_timestamp_synchronizer.f
rtl/msts_pkg.sv
rtl/msts_cell.sv
rtl/multi_stream_timestamp_synchronizer.sv
dv/multi_stream_timestamp_synchronizer_tb.sv
